FILE: rtl/gri_pkg.sv
package gri_pkg;

  // Calibration length and channel count.
  localparam int CAL_SAMPLES = 100;
  localparam int NUM_CH      = 6;
  localparam int CH_W        = 3;

  // Field widths.
  localparam int RAW_W     = 16;
  localparam int DB_W      = 15;
  localparam int SCALE_W   = 24;
  localparam int BIAS_W    = 25;
  localparam int DIFF_W    = 26;
  localparam int PROD_W    = DIFF_W + SCALE_W;
  localparam int ACC_W     = 64;
  localparam int ANGLE_W   = 48;
  localparam int ANGLE_LSB = 16;

  // Calibration sums and the bias divider.
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = RAW_W + 1 + $clog2(CAL_SAMPLES);
  localparam int X_W   = SUM_W + 8;
  localparam int N_W   = $clog2(CAL_SAMPLES + 1);
  localparam logic [63:0]      RECIP_FULL = (64'd1 << X_W) / 64'(CAL_SAMPLES);
  localparam logic [X_W:0]     DIV_RECIP  = RECIP_FULL[X_W:0];
  localparam logic [N_W-1:0]   DIV_N      = N_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(CAL_SAMPLES - 1);
  localparam logic [CH_W-1:0]  CH_LAST    = CH_W'(NUM_CH - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE = 1'd1;
  localparam logic [DB_W-1:0]      DEADBAND_RST   = 15'd10;
  localparam logic [SCALE_W-1:0]   RATE_SCALE_RST = 24'd31877;

  // Queues.
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 3);

  typedef enum logic [1:0] {
    ITEM_CAL,
    ITEM_CAL_DONE,
    ITEM_MEAS
  } item_kind_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_POST
  } back_state_t;

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef sum_t [NUM_CH-1:0]        sum_vec_t;

  typedef struct packed {
    logic              func;
    logic [RAW_W-1:0]  channel_0;
    logic [RAW_W-1:0]  channel_1;
    logic [RAW_W-1:0]  channel_2;
    logic [RAW_W-1:0]  channel_3;
    logic [RAW_W-1:0]  channel_4;
    logic [RAW_W-1:0]  channel_5;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_0;
    logic signed [ANGLE_W-1:0] angle_1;
    logic signed [ANGLE_W-1:0] angle_2;
    logic signed [ANGLE_W-1:0] angle_3;
    logic signed [ANGLE_W-1:0] angle_4;
    logic signed [ANGLE_W-1:0] angle_5;
    logic                      calibrated;
  } out_item_t;

  typedef struct packed {
    item_kind_t         kind;
    logic               calibrated;
    logic [NUM_CH-1:0]  active;
    raw_t [NUM_CH-1:0]  raw;
    sum_vec_t           sum;
  } mid_entry_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic [CH_W-1:0] ch;
    bias_t           value;
  } bias_wr_t;

endpackage

FILE: rtl/gyro_rate_calibrate_integrate.sv
// Path: an accepted beat passes the front queue, the difference and product registers
// and the 64-bit accumulate into the result queue. A calibration-completing beat holds the
// back while the six biases are divided out one channel per cycle. Throughput: one beat
// per cycle while the result queue has room for the beats in flight and no division runs.
// Reset (rst_n low, synchronous) empties both queues, clears sums, biases, angles,
// the sample count and the calibrated flag, and restores deadband and rate_scale.
module gyro_rate_calibrate_integrate import gri_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The configuration registers are shared by both halves: the deadband is
  // applied when an item is classified in the front, the rate scale when the
  // back multiplies the bias-corrected rate.
  logic [DB_W-1:0]    deadband_r;
  logic [SCALE_W-1:0] rate_scale_r;

  // Front to back: one queue entry per accepted beat, already classified as a
  // calibration sample, the sample that completes a calibration, or a
  // measurement.
  logic       mid_valid;
  mid_entry_t mid_head;
  logic       mid_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r   <= DEADBAND_RST;
      rate_scale_r <= RATE_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEADBAND:   deadband_r   <= cfg_data[DB_W-1:0];
        CFG_RATE_SCALE: rate_scale_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // The front accepts a beat every cycle while its queue has room. It keeps
  // the calibration sums, so a completing sample carries the final sums down
  // to the back, where the divider turns them into biases before any later
  // measurement is issued.
  gri_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .deadband  (deadband_r),
    .mid_valid (mid_valid),
    .mid_head  (mid_head),
    .mid_pop   (mid_pop)
  );

  // The back runs a three-stage multiply-accumulate for all six channels and
  // writes each finished beat into a small result queue; it issues only when
  // that queue has room for everything already in flight.
  gri_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_valid  (mid_valid),
    .mid_head   (mid_head),
    .mid_pop    (mid_pop),
    .rate_scale (rate_scale_r),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule

FILE: rtl/gri_front.sv
module gri_front import gri_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  in_item_t        in_item,
  input  logic [DB_W-1:0] deadband,
  output logic            mid_valid,
  output mid_entry_t      mid_head,
  input  logic            mid_pop
);

  logic                 accept;
  logic                 cal_last;
  raw_t                 raw     [NUM_CH];
  logic [RAW_W-1:0]     mag     [NUM_CH];
  sum_t                 sum_add [NUM_CH];
  sum_t                 sum_r   [NUM_CH];
  logic [CNT_W-1:0]     cnt_r;
  logic                 calib_r;
  mid_entry_t           entry;
  mid_entry_t           mid_q   [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_r;
  logic [MID_PTR_W-1:0] rd_ptr_r;
  logic [MID_CNT_W-1:0] mid_cnt_r;

  assign raw[0] = raw_t'(in_item.channel_0);
  assign raw[1] = raw_t'(in_item.channel_1);
  assign raw[2] = raw_t'(in_item.channel_2);
  assign raw[3] = raw_t'(in_item.channel_3);
  assign raw[4] = raw_t'(in_item.channel_4);
  assign raw[5] = raw_t'(in_item.channel_5);

  assign full      = (mid_cnt_r == MID_CNT_W'(MID_DEPTH));
  assign accept    = push && !full;
  assign mid_valid = (mid_cnt_r != '0);
  assign mid_head  = mid_q[rd_ptr_r];
  assign cal_last  = (cnt_r == CNT_LAST);

  // Classify the item and build its queue entry.
  always_comb begin
    entry            = '0;
    entry.kind       = in_item.func ? ITEM_MEAS : (cal_last ? ITEM_CAL_DONE : ITEM_CAL);
    entry.calibrated = calib_r || (!in_item.func && cal_last);
    for (int i = 0; i < NUM_CH; i++) begin
      mag[i]          = raw[i][RAW_W-1] ? RAW_W'(-raw[i]) : RAW_W'(raw[i]);
      sum_add[i]      = sum_r[i] + SUM_W'(raw[i]);
      entry.active[i] = (mag[i] >= {1'b0, deadband});
      entry.raw[i]    = raw[i];
      entry.sum[i]    = sum_add[i];
    end
  end

  // Calibration sums, sample count and calibrated flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      calib_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        sum_r[i] <= '0;
      end
    end else if (accept && !in_item.func) begin
      if (cal_last) begin
        cnt_r   <= '0;
        calib_r <= 1'b1;
        for (int i = 0; i < NUM_CH; i++) begin
          sum_r[i] <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        for (int i = 0; i < NUM_CH; i++) begin
          sum_r[i] <= sum_add[i];
        end
      end
    end
  end

  // Queue between the front and the back.
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_q[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      mid_cnt_r <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (mid_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (accept && !mid_pop) begin
        mid_cnt_r <= mid_cnt_r + 1'b1;
      end else if (!accept && mid_pop) begin
        mid_cnt_r <= mid_cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/gri_bias_div.sv
module gri_bias_div import gri_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  sum_vec_t sums,
  output bias_wr_t bias_wr
);

  logic                 run_r;
  logic [CH_W-1:0]      ch_r;
  sum_t                 s_sel;
  logic [SUM_W-1:0]     mag_sel;
  logic                 v0_r, v1_r, v2_r, v3_r;
  logic                 neg0_r, neg1_r, neg2_r;
  logic [CH_W-1:0]      ch0_r, ch1_r, ch2_r, ch3_r;
  logic [X_W-1:0]       x0_r, x1_r;
  logic [2*X_W:0]       prod1_r;
  logic [X_W-1:0]       q0;
  logic [X_W+N_W-1:0]   qn;
  logic [X_W-1:0]       q2_r, r2_r;
  logic [X_W-1:0]       qfix;
  bias_t                val3_r;

  // The quotient estimate from the reciprocal is exact or one short.
  assign s_sel   = sums[ch_r];
  assign mag_sel = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
  assign q0      = prod1_r[2*X_W-1:X_W];
  assign qn      = q0 * DIV_N;
  assign qfix    = q2_r + X_W'(r2_r >= X_W'(DIV_N));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      ch_r  <= '0;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (start) begin
        run_r <= 1'b1;
        ch_r  <= '0;
      end else if (run_r) begin
        ch_r <= ch_r + 1'b1;
        if (ch_r == CH_LAST) begin
          run_r <= 1'b0;
        end
      end
      v0_r <= run_r;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x0_r    <= {mag_sel, 8'b0};
    neg0_r  <= s_sel[SUM_W-1];
    ch0_r   <= ch_r;
    prod1_r <= x0_r * DIV_RECIP;
    x1_r    <= x0_r;
    neg1_r  <= neg0_r;
    ch1_r   <= ch0_r;
    q2_r    <= q0;
    r2_r    <= x1_r - qn[X_W-1:0];
    neg2_r  <= neg1_r;
    ch2_r   <= ch1_r;
    val3_r  <= neg2_r ? bias_t'(BIAS_W'(0) - BIAS_W'(qfix)) : bias_t'(BIAS_W'(qfix));
    ch3_r   <= ch2_r;
  end

  assign bias_wr.valid = v3_r;
  assign bias_wr.last  = (ch3_r == CH_LAST);
  assign bias_wr.ch    = ch3_r;
  assign bias_wr.value = val3_r;

endmodule

FILE: rtl/gri_back.sv
module gri_back import gri_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_valid,
  input  mid_entry_t         mid_head,
  output logic               mid_pop,
  input  logic [SCALE_W-1:0] rate_scale,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item
);

  back_state_t                state_r, state_nxt;
  logic                       start_div;
  bias_wr_t                   bias_wr;
  bias_t                      bias_r   [NUM_CH];
  logic                       credit_ok;
  logic                       issue;
  logic                       out_take;
  logic                       v1_r, v2_r;
  logic                       cal1_r, cal2_r;
  logic signed [DIFF_W-1:0]   scaled   [NUM_CH];
  logic signed [DIFF_W-1:0]   diff_nxt [NUM_CH];
  logic signed [DIFF_W-1:0]   diff1_r  [NUM_CH];
  logic signed [PROD_W-1:0]   prod2_r  [NUM_CH];
  logic [ACC_W-1:0]           acc_r    [NUM_CH];
  logic [ACC_W-1:0]           acc_nxt  [NUM_CH];
  out_item_t                  out_wr;
  out_item_t                  out_q    [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]       owr_ptr_r;
  logic [OUT_PTR_W-1:0]       ord_ptr_r;
  logic [OUT_CNT_W-1:0]       out_cnt_r;

  gri_bias_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_div),
    .sums    (mid_head.sum),
    .bias_wr (bias_wr)
  );

  // Room in the result queue for everything already in the pipeline.
  assign credit_ok = (out_cnt_r + OUT_CNT_W'(v1_r) + OUT_CNT_W'(v2_r))
                     < OUT_CNT_W'(OUT_DEPTH);
  assign mid_pop   = issue;
  assign empty     = (out_cnt_r == '0);
  assign out_take  = pop && !empty;
  assign out_item  = out_q[ord_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    start_div = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      BK_RUN: begin
        if (mid_valid) begin
          if (mid_head.kind == ITEM_CAL_DONE) begin
            start_div = 1'b1;
            state_nxt = BK_DIV;
          end else begin
            issue = credit_ok;
          end
        end
      end
      BK_DIV: begin
        if (bias_wr.valid && bias_wr.last) begin
          state_nxt = BK_POST;
        end
      end
      BK_POST: begin
        if (mid_valid && credit_ok) begin
          issue     = 1'b1;
          state_nxt = BK_RUN;
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  // Bias-corrected rate; zero for calibration items and deadband channels.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      scaled[i] = DIFF_W'($signed({mid_head.raw[i], 8'b0}));
      if (mid_head.kind == ITEM_MEAS && mid_head.active[i]) begin
        diff_nxt[i] = scaled[i] - DIFF_W'(bias_r[i]);
      end else begin
        diff_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        bias_r[i] <= '0;
      end
    end else if (bias_wr.valid) begin
      bias_r[bias_wr.ch] <= bias_wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cal1_r <= mid_head.calibrated;
      for (int i = 0; i < NUM_CH; i++) begin
        diff1_r[i] <= diff_nxt[i];
      end
    end
    if (v1_r) begin
      cal2_r <= cal1_r;
      for (int i = 0; i < NUM_CH; i++) begin
        prod2_r[i] <= diff1_r[i] * $signed({1'b0, rate_scale});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      acc_nxt[i] = acc_r[i] + ACC_W'(prod2_r[i]);
    end
    out_wr.angle_0    = acc_nxt[0][ACC_W-1:ANGLE_LSB];
    out_wr.angle_1    = acc_nxt[1][ACC_W-1:ANGLE_LSB];
    out_wr.angle_2    = acc_nxt[2][ACC_W-1:ANGLE_LSB];
    out_wr.angle_3    = acc_nxt[3][ACC_W-1:ANGLE_LSB];
    out_wr.angle_4    = acc_nxt[4][ACC_W-1:ANGLE_LSB];
    out_wr.angle_5    = acc_nxt[5][ACC_W-1:ANGLE_LSB];
    out_wr.calibrated = cal2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        acc_r[i] <= '0;
      end
    end else if (v2_r) begin
      for (int i = 0; i < NUM_CH; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

  // Result queue.
  always_ff @(posedge clk) begin
    if (v2_r) begin
      out_q[owr_ptr_r] <= out_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      out_cnt_r <= '0;
    end else begin
      if (v2_r) begin
        owr_ptr_r <= owr_ptr_r + 1'b1;
      end
      if (out_take) begin
        ord_ptr_r <= ord_ptr_r + 1'b1;
      end
      if (v2_r && !out_take) begin
        out_cnt_r <= out_cnt_r + 1'b1;
      end else if (!v2_r && out_take) begin
        out_cnt_r <= out_cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(v2_r && !out_take && out_cnt_r == OUT_CNT_W'(OUT_DEPTH)))
    else $error("result queue written while full");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_cnt_r + OUT_CNT_W'(v1_r) + OUT_CNT_W'(v2_r)) <= OUT_CNT_W'(OUT_DEPTH))
    else $error("pipeline holds more beats than the result queue can take");

  a_bias_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    bias_wr.valid |-> state_r == BK_DIV)
    else $error("bias written outside the division phase");

  a_no_issue_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> !issue)
    else $error("beat issued while the bias is being computed");

  a_start_head: assert property (@(posedge clk) disable iff (!rst_n)
    start_div |=> state_r == BK_DIV && mid_valid && mid_head.kind == ITEM_CAL_DONE)
    else $error("calibration head lost during the division");

endmodule
